@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the stroke word unit.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define SWSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define SWSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/swsw_pkg.sv @@
// Package of the stroke word scale and wrap unit: types, constants, saturation.
// No dependencies.
package swsw_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_FLUSH, S_WWAIT, S_WDEC, S_CRD, S_CSC, S_CWAIT,
    S_PRD, S_PCH, S_PSX, S_PWX, S_PSY, S_PWY, S_OUT
  } state_t;

  localparam int POS_W  = 20;
  localparam int SCI_W  = 21;
  localparam int SC_W   = 25;
  localparam int ACC_W  = 32;
  localparam int FS_W   = 16;
  localparam int LIM_W  = 19;
  localparam int PEN_W  = 8;
  localparam int GAP_W  = 14;

  localparam logic [1:0] REG_FONT_SIZE  = 2'd0;
  localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MAX_HEIGHT = 2'd2;

  localparam logic [FS_W-1:0]  FS_RESET = 16'd2560;
  localparam logic [LIM_W-1:0] MW_RESET = 19'd25600;
  localparam logic [LIM_W-1:0] MH_RESET = 19'd25600;

  localparam logic signed [POS_W-1:0] POS_MAX = 20'sd524287;
  localparam logic signed [POS_W-1:0] POS_MIN = -20'sd524288;

  // floor((v*fs + 2304) / 4608) as floor(floor(./512) / 9)
  localparam logic signed [37:0] SCALE_RND  = 38'sd2304;
  localparam logic signed [31:0] SCALE_BIAS = 32'sd1207959552;  // 9 * 2^27
  localparam logic [30:0]        SCALE_MUL  = 31'd1908874354;   // ceil(2^34 / 9)
  localparam logic signed [28:0] SCALE_OFS  = 29'sd134217728;   // 2^27

  localparam logic [17:0] LINE_GAP = 18'd1280;
  localparam logic [15:0] GAP_MUL  = 16'd52429;                 // ceil(2^18 / 5)

  function automatic logic signed [POS_W-1:0] sat20(input logic signed [ACC_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 32'sd524287) r = POS_MAX;
    else if (v < -32'sd524288) r = POS_MIN;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/swsw_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module swsw_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/swsw_scale.sv @@
// Three-stage scaler: floor((v*font_size + 2304) / 4608), divide by 9 via reciprocal.
// Depends on swsw_pkg.
module swsw_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [swsw_pkg::SCI_W-1:0]    in_v,
  input  logic        [swsw_pkg::FS_W-1:0]     font_size,
  output logic                                 out_valid,
  output logic signed [swsw_pkg::SC_W-1:0]     out_s
);

  logic signed [37:0] prod0;
  logic signed [37:0] p1_r;
  logic signed [31:0] ub;
  logic [30:0]        u_r;
  logic [61:0]        prod_r;
  logic signed [28:0] quo;
  logic               v1_r, v2_r, v3_r;

  assign prod0 = in_v * $signed({1'b0, font_size});
  assign ub    = {{3{p1_r[37]}}, p1_r[37:9]} + swsw_pkg::SCALE_BIAS;
  assign quo   = $signed({1'b0, prod_r[61:34]}) - swsw_pkg::SCALE_OFS;
  assign out_s = quo[swsw_pkg::SC_W-1:0];
  assign out_valid = v3_r;

  always_ff @(posedge clk) begin
    p1_r   <= prod0 + swsw_pkg::SCALE_RND;
    u_r    <= ub[30:0];
    prod_r <= u_r * swsw_pkg::SCALE_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

endmodule

@@ rtl/stroke_word_scale_and_wrap_unit.sv @@
// Stroke word scale and wrap unit: buffers a word's points, lays them out in mm.
// Load: points are accepted only while idle; in_stall is high during layout. At word end:
// word width, then each character's width, then per emitted point a point read, a char
// read and two passes through the single shared 3-stage scaler, with registered RAM reads.
// Reset (synchronous, rst_n low): config to defaults, cursor zero, word state cleared.
// Point and character RAMs are not cleared; entries are written before use.
module stroke_word_scale_and_wrap_unit #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_CHARS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [19:0] in_x_value,
  input  logic signed [19:0] in_y_value,
  input  logic [7:0]         in_pen,
  input  logic               in_char_end,
  input  logic               in_word_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_x,
  output logic signed [19:0] out_y,
  output logic [7:0]         out_pen,
  output logic               out_last,
  output logic               out_word_dropped,
  output logic               out_overflow,
  output logic signed [19:0] out_next_cursor_x,
  output logic signed [19:0] out_next_cursor_y
);

  localparam int PA   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PC   = $clog2(MAX_POINTS + 1);
  localparam int CA   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CC   = $clog2(MAX_CHARS + 1);
  localparam int PW   = swsw_pkg::POS_W;
  localparam int PT_W = 2 * PW + swsw_pkg::PEN_W + CA;
  localparam int CH_W = 2 * PW + swsw_pkg::ACC_W;
  localparam int AW   = swsw_pkg::ACC_W;

  swsw_pkg::state_t state_r, state_nxt;

  logic [swsw_pkg::FS_W-1:0]  fs_r;
  logic [swsw_pkg::LIM_W-1:0] mw_r, mh_r;
  logic [swsw_pkg::GAP_W-1:0] gap_r;
  logic signed [PW-1:0] cur_x_r, cur_y_r, wmin_r, wmax_r, cmin_r, cmax_r;
  logic [PC-1:0] pcnt_r;
  logic [CC-1:0] ccnt_r;
  logic [CA-1:0] last_ci_r, ci_r;
  logic          cnew_r, lost_r;
  logic [PA-1:0] i_r;
  logic signed [swsw_pkg::SC_W-1:0] s_r, sx_r;
  logic signed [AW-1:0] acc_r, start_r;
  logic signed [21:0]   base_r;
  logic signed [PW-1:0] nx_r, ny_r, pt_x_r, pt_y_r, ox_r, oy_r;
  logic [7:0]           pt_pen_r, open_r;
  logic                 olast_r, odrop_r;

  // transaction decode
  logic in_acc, ld, room, store, go_layout, clear_empty, cfg_we;
  logic signed [PW-1:0] nmin, nmax;

  assign in_stall    = (state_r != swsw_pkg::S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign ld          = in_acc && !in_command;
  assign room        = (pcnt_r < PC'(MAX_POINTS)) && (ccnt_r < CC'(MAX_CHARS));
  assign store       = ld && room;
  assign go_layout   = ld && in_word_end && (store || (pcnt_r != '0));
  assign clear_empty = ld && in_word_end && !go_layout;
  assign cfg_we      = psel && penable && pwrite;
  assign nmin = (cnew_r || (in_x_value < cmin_r)) ? in_x_value : cmin_r;
  assign nmax = (cnew_r || (in_x_value > cmax_r)) ? in_x_value : cmax_r;

  // memories
  logic            pm_we, cm_we;
  logic [PA-1:0]   pm_waddr;
  logic [CA-1:0]   cm_waddr, cm_raddr, pm_rci;
  logic [PT_W-1:0] pm_wdata, pm_rdata;
  logic [CH_W-1:0] cm_wdata, cm_rdata;
  logic signed [PW-1:0] cm_min, cm_max;
  logic signed [AW-1:0] cm_start;

  assign pm_we    = store;
  assign pm_waddr = pcnt_r[PA-1:0];
  assign pm_wdata = {in_x_value, in_y_value, in_pen, ccnt_r[CA-1:0]};
  assign pm_rci   = pm_rdata[CA-1:0];
  assign cm_min   = cm_rdata[CH_W-1 -: PW];
  assign cm_max   = cm_rdata[CH_W-PW-1 -: PW];
  assign cm_start = cm_rdata[AW-1:0];
  assign cm_raddr = (state_r == swsw_pkg::S_PCH) ? pm_rci : ci_r;

  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = ccnt_r[CA-1:0];
    cm_wdata = {nmin, nmax, {AW{1'b0}}};
    priority if (store && in_char_end) begin
      cm_we = 1'b1;
    end else if (state_r == swsw_pkg::S_FLUSH && !cnew_r) begin
      cm_we    = 1'b1;
      cm_wdata = {cmin_r, cmax_r, {AW{1'b0}}};
    end else if (state_r == swsw_pkg::S_CSC) begin
      cm_we    = 1'b1;
      cm_waddr = ci_r;
      cm_wdata = {cm_min, cm_max, acc_r};
    end else begin
      cm_we = 1'b0;
    end
  end

  swsw_ram #(.DEPTH(MAX_POINTS), .AW(PA), .DW(PT_W)) u_pmem (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(i_r), .rdata(pm_rdata)
  );

  swsw_ram #(.DEPTH(MAX_CHARS), .AW(CA), .DW(CH_W)) u_cmem (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata)
  );

  // scaler
  logic sc_iv, sc_ov;
  logic signed [swsw_pkg::SCI_W-1:0] sc_in;
  logic signed [swsw_pkg::SC_W-1:0]  sc_out;

  function automatic logic signed [swsw_pkg::SCI_W-1:0] SCI_EXT(input logic signed [PW-1:0] v);
    return swsw_pkg::SCI_W'(v);
  endfunction

  always_comb begin
    sc_iv = 1'b1;
    unique case (state_r)
      swsw_pkg::S_FLUSH: sc_in = SCI_EXT(wmax_r) - SCI_EXT(wmin_r);
      swsw_pkg::S_CSC:   sc_in = SCI_EXT(cm_max) - SCI_EXT(cm_min);
      swsw_pkg::S_PSX:   sc_in = SCI_EXT(pt_x_r) - SCI_EXT(cm_min);
      swsw_pkg::S_PSY:   sc_in = SCI_EXT(pt_y_r);
      default: begin
        sc_iv = 1'b0;
        sc_in = '0;
      end
    endcase
  end

  swsw_scale u_scale (
    .clk(clk), .rst_n(rst_n), .in_valid(sc_iv), .in_v(sc_in),
    .font_size(fs_r), .out_valid(sc_ov), .out_s(sc_out)
  );

  // word decision
  logic signed [26:0] wide_x;
  logic               wrap, drop;
  logic signed [21:0] base_w;
  logic signed [22:0] neg_base;
  logic signed [AW-1:0] acc_nxt;
  logic               last_pt;

  assign wide_x   = 27'(cur_x_r) + 27'(s_r);
  assign wrap     = wide_x > $signed({8'b0, mw_r});
  assign base_w   = wrap ? (22'(cur_y_r) - $signed({4'b0, {2'b0, fs_r} + swsw_pkg::LINE_GAP}))
                         : 22'(cur_y_r);
  assign neg_base = -23'(base_w);
  assign drop     = neg_base > $signed({4'b0, mh_r});
  assign acc_nxt  = acc_r + AW'(sc_out) + $signed({{(AW-swsw_pkg::GAP_W){1'b0}}, gap_r});
  assign last_pt  = (PC'(i_r) + PC'(1)) == pcnt_r;

  // letter gap floor((3*fs + 10) / 20)
  logic [17:0] gn;
  logic [31:0] gprod;
  assign gn    = {2'b0, fs_r} + {1'b0, fs_r, 1'b0} + 18'd10;
  assign gprod = gn[17:2] * swsw_pkg::GAP_MUL;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swsw_pkg::S_IDLE:  if (go_layout) state_nxt = swsw_pkg::S_FLUSH;
      swsw_pkg::S_FLUSH: state_nxt = swsw_pkg::S_WWAIT;
      swsw_pkg::S_WWAIT: if (sc_ov) state_nxt = swsw_pkg::S_WDEC;
      swsw_pkg::S_WDEC:  state_nxt = drop ? swsw_pkg::S_OUT : swsw_pkg::S_CRD;
      swsw_pkg::S_CRD:   state_nxt = swsw_pkg::S_CSC;
      swsw_pkg::S_CSC:   state_nxt = swsw_pkg::S_CWAIT;
      swsw_pkg::S_CWAIT: begin
        if (sc_ov) state_nxt = (ci_r == last_ci_r) ? swsw_pkg::S_PRD : swsw_pkg::S_CRD;
      end
      swsw_pkg::S_PRD:   state_nxt = swsw_pkg::S_PCH;
      swsw_pkg::S_PCH:   state_nxt = swsw_pkg::S_PSX;
      swsw_pkg::S_PSX:   state_nxt = swsw_pkg::S_PWX;
      swsw_pkg::S_PWX:   if (sc_ov) state_nxt = swsw_pkg::S_PSY;
      swsw_pkg::S_PSY:   state_nxt = swsw_pkg::S_PWY;
      swsw_pkg::S_PWY:   if (sc_ov) state_nxt = swsw_pkg::S_OUT;
      swsw_pkg::S_OUT: begin
        if (!out_stall) state_nxt = olast_r ? swsw_pkg::S_IDLE : swsw_pkg::S_PRD;
      end
      default: state_nxt = swsw_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid         = (state_r == swsw_pkg::S_OUT);
    out_x             = ox_r;
    out_y             = oy_r;
    out_pen           = open_r;
    out_last          = olast_r;
    out_word_dropped  = odrop_r;
    out_overflow      = lost_r;
    out_next_cursor_x = nx_r;
    out_next_cursor_y = ny_r;
    pready            = 1'b1;
    unique case (paddr[3:2])
      swsw_pkg::REG_FONT_SIZE:  prdata = {16'b0, fs_r};
      swsw_pkg::REG_MAX_WIDTH:  prdata = {13'b0, mw_r};
      swsw_pkg::REG_MAX_HEIGHT: prdata = {13'b0, mh_r};
      default:                  prdata = '0;
    endcase
  end

  logic word_done, clear_word;
  assign word_done  = (state_r == swsw_pkg::S_OUT) && !out_stall && olast_r;
  assign clear_word = word_done || clear_empty;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swsw_pkg::S_IDLE;
      fs_r    <= swsw_pkg::FS_RESET;
      mw_r    <= swsw_pkg::MW_RESET;
      mh_r    <= swsw_pkg::MH_RESET;
      cur_x_r <= '0;
      cur_y_r <= '0;
      wmin_r  <= swsw_pkg::POS_MAX;
      wmax_r  <= swsw_pkg::POS_MIN;
      pcnt_r  <= '0;
      ccnt_r  <= '0;
      cnew_r  <= 1'b1;
      lost_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (paddr[3:2])
          swsw_pkg::REG_FONT_SIZE:  fs_r <= pwdata[15:0];
          swsw_pkg::REG_MAX_WIDTH:  mw_r <= pwdata[18:0];
          swsw_pkg::REG_MAX_HEIGHT: mh_r <= pwdata[18:0];
          default: ;
        endcase
      end
      if (in_acc && in_command) begin
        cur_x_r <= in_x_value;
        cur_y_r <= in_y_value;
      end
      if (word_done && !odrop_r) begin
        cur_x_r <= nx_r;
        cur_y_r <= ny_r;
      end
      if (store) begin
        if (in_x_value < wmin_r) wmin_r <= in_x_value;
        if (in_x_value > wmax_r) wmax_r <= in_x_value;
        pcnt_r <= pcnt_r + PC'(1);
        if (in_char_end) ccnt_r <= ccnt_r + CC'(1);
        cnew_r <= in_char_end;
      end else if (ld && !clear_empty) begin
        lost_r <= 1'b1;
      end
      if (clear_word) begin
        wmin_r <= swsw_pkg::POS_MAX;
        wmax_r <= swsw_pkg::POS_MIN;
        pcnt_r <= '0;
        ccnt_r <= '0;
        cnew_r <= 1'b1;
        lost_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    gap_r <= gprod[31:18];
    if (store) begin
      cmin_r    <= nmin;
      cmax_r    <= nmax;
      last_ci_r <= ccnt_r[CA-1:0];
    end
    unique case (state_r)
      swsw_pkg::S_WWAIT: if (sc_ov) s_r <= sc_out;
      swsw_pkg::S_WDEC: begin
        acc_r  <= wrap ? '0 : AW'(cur_x_r);
        base_r <= base_w;
        ny_r   <= drop ? cur_y_r : swsw_pkg::sat20(AW'(base_w));
        ci_r   <= '0;
        i_r    <= '0;
        if (drop) begin
          ox_r    <= '0;
          oy_r    <= '0;
          open_r  <= '0;
          olast_r <= 1'b1;
          odrop_r <= 1'b1;
          nx_r    <= cur_x_r;
        end
      end
      swsw_pkg::S_CWAIT: begin
        if (sc_ov) begin
          acc_r <= acc_nxt;
          if (ci_r == last_ci_r) nx_r <= swsw_pkg::sat20(acc_nxt);
          else ci_r <= ci_r + CA'(1);
        end
      end
      swsw_pkg::S_PCH: begin
        pt_x_r   <= pm_rdata[PT_W-1 -: PW];
        pt_y_r   <= pm_rdata[PT_W-PW-1 -: PW];
        pt_pen_r <= pm_rdata[CA +: 8];
      end
      swsw_pkg::S_PSX: start_r <= cm_start;
      swsw_pkg::S_PWX: if (sc_ov) sx_r <= sc_out;
      swsw_pkg::S_PWY: begin
        if (sc_ov) begin
          ox_r    <= swsw_pkg::sat20(start_r + AW'(sx_r));
          oy_r    <= swsw_pkg::sat20(AW'(base_r) + AW'(sc_out));
          open_r  <= pt_pen_r;
          olast_r <= last_pt;
          odrop_r <= 1'b0;
        end
      end
      swsw_pkg::S_OUT: if (!out_stall && !olast_r) i_r <= i_r + PA'(1);
      default: ;
    endcase
  end

endmodule

@@ rtl/swsw_checker.sv @@
// Port-level checker for the stroke word unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module swsw_prop_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [19:0] out_x,
  input logic signed [19:0] out_y,
  input logic [7:0]         out_pen,
  input logic               out_last,
  input logic               out_word_dropped,
  input logic signed [19:0] out_next_cursor_x
);

  `SWSW_ASSERT(a_busy_while_out, out_valid |-> in_stall, "input taken while result pending")
  `SWSW_ASSERT(a_drop_form, (out_valid && out_word_dropped) |-> (out_last && out_x == 20'sd0 && out_y == 20'sd0 && out_pen == 8'd0), "bad dropped result")
  `SWSW_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_next_cursor_x)), "stalled result changed")
  `SWSW_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result after reset")

endmodule

bind stroke_word_scale_and_wrap_unit swsw_prop_checker u_swsw_checker (.*);
